FILE: rtl/assert_macros.svh
// Assertion macros included by the frame parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/tif_pkg.sv
// Teleinfo parser package: character codes and the label table
package tif_pkg;

  localparam logic [6:0] CH_STX = 7'h02;
  localparam logic [6:0] CH_ETX = 7'h03;
  localparam logic [6:0] CH_LF  = 7'h0A;
  localparam logic [6:0] CH_CR  = 7'h0D;
  localparam logic [6:0] CH_SP  = 7'h20;

  localparam int TABLE_SIZE = 20;
  localparam int IDX_PAPP   = 13;
  localparam int IDX_ADIR1  = 17;
  localparam int CSUM_MASK  = 63;
  localparam int CSUM_BIAS  = 32;

  typedef struct packed {
    logic [55:0] chars;
    logic [3:0]  len;
  } label_entry_t;

  // Labels as 8-bit strings, right aligned, with their lengths
  localparam logic [63:0] LABEL_STR [TABLE_SIZE] = '{
    64'("ADCO"), 64'("OPTARIF"), 64'("ISOUSC"), 64'("HCHP"), 64'("HCHC"),
    64'("PTEC"), 64'("IINST1"), 64'("IINST2"), 64'("IINST3"), 64'("IMAX1"),
    64'("IMAX2"), 64'("IMAX3"), 64'("PMAX"), 64'("PAPP"), 64'("HHPHC"),
    64'("MOTDETAT"), 64'("PPOT"), 64'("ADIR1"), 64'("ADIR2"), 64'("ADIR3")};
  localparam logic [3:0] LABEL_LEN [TABLE_SIZE] = '{
    4'd4, 4'd7, 4'd6, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd5,
    4'd5, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd4, 4'd5, 4'd5, 4'd5};

  // Repack one table label to 7 bits a character, first character low
  function automatic label_entry_t label_rom(input int idx);
    label_entry_t e;
    int n;
    e.chars = '0;
    e.len   = LABEL_LEN[idx];
    n       = int'(LABEL_LEN[idx]);
    for (int k = 0; k < 8; k++) begin
      if (k < n) begin
        e.chars[7*k +: 7] = LABEL_STR[idx][8*(n-1-k) +: 7];
      end
    end
    return e;
  endfunction

endpackage

FILE: rtl/teleinfo_frame_parser.sv
// Teleinfo historique frame parser, one character word per cycle
// The parser takes one 7-bit meter character per cycle and never stalls
// except while a finished result waits at the output register. At the CR
// of a good-shaped group it emits a group result (label index, checksum
// verdict, value up to MAX_VALUE_CHARS characters); at the ETX closing a
// frame (sync is ETX then STX) it emits a frame result.
// out_tuser is 0 for a group result, 1 for a frame result.
module teleinfo_frame_parser
  import tif_pkg::*;
#(
  parameter int NUM_LABELS      = 20,
  parameter int MAX_VALUE_CHARS = 16,
  parameter int MAX_LABEL_CHARS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [6:0] rx_char
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // label_index, csum_good, value_length,
                                   // value_first, value_rest, value_overflow,
                                   // frame_checksum_error, overload_phase,
                                   // power_missing
  output logic         out_tuser   // kind
);

`include "assert_macros.svh"

  typedef enum logic [2:0] {PH_IDLE, PH_LABEL, PH_VALUE, PH_CSUM, PH_CR} phase_t;

  logic        etx_seen_r, etx_seen_nxt;
  logic        in_frame_r, in_frame_nxt;
  phase_t      phase_r, phase_nxt;
  logic [55:0] label_buf_r, label_buf_nxt;
  logic [3:0]  label_cnt_r, label_cnt_nxt;
  logic [6:0]  value_buf_r [16];
  logic [4:0]  value_cnt_r, value_cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [6:0]  rx_cs_r, rx_cs_nxt;
  logic        frame_err_r, frame_err_nxt;
  logic [2:0]  ovl_r, ovl_nxt;
  logic        power_r, power_nxt;
  logic        val_we;
  logic [3:0]  val_widx;

  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic         out_kind_r;
  logic         res_valid, res_kind;
  logic [127:0] res_data;

  logic        accept;
  logic [6:0]  c;
  logic [4:0]  idx;
  logic [4:0]  kept;
  logic        ok;
  logic [55:0] lo, hi;
  logic [1:0]  ph;
  label_entry_t ent;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign c         = in_tdata[6:0];

  // Match the collected label against the table
  always_comb begin
    idx = 5'(NUM_LABELS);
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      ent = label_rom(i);
      if (i < NUM_LABELS && ent.len == label_cnt_r &&
          int'(ent.len) <= MAX_LABEL_CHARS && ent.chars == label_buf_r) begin
        idx = 5'(i);
      end
    end
  end

  // Pack kept value chars, zeros past length; checksum, overload phase
  always_comb begin
    kept = (int'(value_cnt_r) > MAX_VALUE_CHARS) ? 5'(MAX_VALUE_CHARS) : value_cnt_r;
    ok   = ((8'(CSUM_MASK) & sum_r) + 8'(CSUM_BIAS)) == {1'b0, rx_cs_r};
    lo   = '0;
    hi   = '0;
    for (int j = 0; j < 16; j++) begin
      if (j < int'(kept)) begin
        if (j < 8) lo[7*j +: 7] = value_buf_r[j];
        else       hi[7*(j-8) +: 7] = value_buf_r[j];
      end
    end
    priority if (ovl_r[0]) ph = 2'd1;
    else if (ovl_r[1])     ph = 2'd2;
    else if (ovl_r[2])     ph = 2'd3;
    else                   ph = 2'd0;
  end

  // Advance the parser by one character
  always_comb begin
    etx_seen_nxt  = etx_seen_r;
    in_frame_nxt  = in_frame_r;
    phase_nxt     = phase_r;
    label_buf_nxt = label_buf_r;
    label_cnt_nxt = label_cnt_r;
    value_cnt_nxt = value_cnt_r;
    sum_nxt       = sum_r;
    rx_cs_nxt     = rx_cs_r;
    frame_err_nxt = frame_err_r;
    ovl_nxt       = ovl_r;
    power_nxt     = power_r;
    val_we        = 1'b0;
    val_widx      = value_cnt_r[3:0];
    res_valid     = 1'b0;
    res_kind      = 1'b0;
    res_data      = '0;
    if (c == CH_ETX) begin
      if (in_frame_r) begin
        res_valid       = 1'b1;
        res_kind        = 1'b1;
        res_data[124]   = frame_err_r || (phase_r != PH_IDLE);
        res_data[126:125] = ph;
        res_data[127]   = !power_r;
        in_frame_nxt    = 1'b0;
      end
      etx_seen_nxt = 1'b1;
    end else if (c == CH_STX && etx_seen_r) begin
      etx_seen_nxt  = 1'b0;
      in_frame_nxt  = 1'b1;
      phase_nxt     = PH_IDLE;
      frame_err_nxt = 1'b0;
      ovl_nxt       = '0;
      power_nxt     = 1'b0;
    end else begin
      etx_seen_nxt = 1'b0;
      if (in_frame_r) begin
        if (c == CH_LF) begin
          if (phase_r != PH_IDLE) frame_err_nxt = 1'b1;
          phase_nxt     = PH_LABEL;
          label_buf_nxt = '0;
          label_cnt_nxt = '0;
          value_cnt_nxt = '0;
          sum_nxt       = '0;
          rx_cs_nxt     = '0;
        end else begin
          unique case (phase_r)
            PH_LABEL: begin
              if (c == CH_CR) begin
                frame_err_nxt = 1'b1;
                phase_nxt     = PH_IDLE;
              end else if (c == CH_SP) begin
                sum_nxt   = sum_r + 8'(CH_SP);
                phase_nxt = PH_VALUE;
              end else begin
                sum_nxt = sum_r + 8'(c);
                if (int'(label_cnt_r) < MAX_LABEL_CHARS) begin
                  label_buf_nxt = label_buf_r | (56'(c) << (7 * int'(label_cnt_r)));
                  label_cnt_nxt = label_cnt_r + 4'd1;
                end else begin
                  label_cnt_nxt = 4'(MAX_LABEL_CHARS + 1);
                end
              end
            end
            PH_VALUE: begin
              if (c == CH_CR) begin
                frame_err_nxt = 1'b1;
                phase_nxt     = PH_IDLE;
              end else if (c == CH_SP) begin
                phase_nxt = PH_CSUM;
              end else begin
                sum_nxt = sum_r + 8'(c);
                if (int'(value_cnt_r) < MAX_VALUE_CHARS) begin
                  val_we        = 1'b1;
                  value_cnt_nxt = value_cnt_r + 5'd1;
                end else begin
                  value_cnt_nxt = 5'(MAX_VALUE_CHARS + 1);
                end
              end
            end
            PH_CSUM: begin
              if (c == CH_CR) begin
                frame_err_nxt = 1'b1;
                phase_nxt     = PH_IDLE;
              end else begin
                rx_cs_nxt = c;
                phase_nxt = PH_CR;
              end
            end
            PH_CR: begin
              phase_nxt = PH_IDLE;
              if (c != CH_CR) begin
                frame_err_nxt = 1'b1;
              end else begin
                res_valid          = 1'b1;
                res_data[4:0]      = idx;
                res_data[5]        = ok;
                res_data[10:6]     = kept;
                res_data[66:11]    = lo;
                res_data[122:67]   = hi;
                res_data[123]      = int'(value_cnt_r) > MAX_VALUE_CHARS;
                if (!ok) begin
                  frame_err_nxt = 1'b1;
                end else if (kept != 5'd0) begin
                  if (int'(idx) == IDX_PAPP) power_nxt = 1'b1;
                  else if (int'(idx) >= IDX_ADIR1 && int'(idx) < IDX_ADIR1 + 3)
                    ovl_nxt = ovl_r | (3'b001 << (int'(idx) - IDX_ADIR1));
                end
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end
    end
  end

  // Hold parser state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etx_seen_r  <= 1'b0;
      in_frame_r  <= 1'b0;
      phase_r     <= PH_IDLE;
      label_buf_r <= '0;
      label_cnt_r <= '0;
      value_cnt_r <= '0;
      sum_r       <= '0;
      rx_cs_r     <= '0;
      frame_err_r <= 1'b0;
      ovl_r       <= '0;
      power_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        etx_seen_r  <= etx_seen_nxt;
        in_frame_r  <= in_frame_nxt;
        phase_r     <= phase_nxt;
        label_buf_r <= label_buf_nxt;
        label_cnt_r <= label_cnt_nxt;
        value_cnt_r <= value_cnt_nxt;
        sum_r       <= sum_nxt;
        rx_cs_r     <= rx_cs_nxt;
        frame_err_r <= frame_err_nxt;
        ovl_r       <= ovl_nxt;
        power_r     <= power_nxt;
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Store value characters and result payload
  always_ff @(posedge clk) begin
    if (accept && val_we) value_buf_r[val_widx] <= c;
    if (accept && res_valid) begin
      out_data_r <= res_data;
      out_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  `ASSERT_IMPLY(a_frame_clean, clk, rst_n, out_tvalid && out_tuser,
                out_tdata[123:0] == '0)
  `ASSERT_IMPLY(a_group_clean, clk, rst_n, out_tvalid && !out_tuser,
                out_tdata[127:124] == '0)
  `ASSERT_IMPLY(a_len_max, clk, rst_n, out_tvalid && !out_tuser,
                int'(out_tdata[10:6]) <= MAX_VALUE_CHARS)

endmodule
